/* hdl/fel_pkg.sv */
package fel_pkg;

  localparam int CLUSTER_BITS = 32;
  localparam int DISK_W       = 40;
  localparam int SPC_W        = 8;
  localparam int BPS_W        = 16;
  localparam int EB_W         = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int LIMIT_W      = 41;
  localparam int BITPOS_W     = CLUSTER_BITS + EB_W;
  localparam int DVD_W        = BITPOS_W - 3;
  localparam int DIV_STEPS    = DVD_W;
  localparam int SECTOR_W     = 34;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_DISK_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPC        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BPS        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BITS = 2'd3;

  typedef struct packed {
    logic               valid;
    logic [LIMIT_W-1:0] limit;
  } lim_t;

  typedef struct packed {
    logic                oor;
    logic [BITPOS_W-1:0] bitpos;
  } item_t;

endpackage

/* hdl/fel_limit.sv */
module fel_limit
  import fel_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DISK_W-1:0]    cfg_wdata,
  output lim_t                 lim,
  output logic [BPS_W-1:0]     bps,
  output logic [EB_W-1:0]      eb
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV1  = 3'd1;
  localparam logic [2:0] S_RAW   = 3'd2;
  localparam logic [2:0] S_DIV2  = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_DATA  = 3'd5;
  localparam logic [2:0] S_DIV3  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam int QW = 48;
  localparam int DW = 28;
  localparam logic [5:0] DIV_LAST = 6'(QW - 1);

  logic [DISK_W-1:0]  disk_r;
  logic [SPC_W-1:0]   spc_r;
  logic [BPS_W-1:0]   bps_r;
  logic [EB_W-1:0]    eb_r;
  logic [2:0]         state_r;
  logic [QW-1:0]      q_r;
  logic [DW:0]        rem_r;
  logic [DW-1:0]      den_r;
  logic [5:0]         cnt_r;
  logic [QW-1:0]      fat_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               valid_r;

  logic [23:0]        cb;
  logic [45:0]        num;
  logic [DW-1:0]      den;
  logic [DW:0]        r2;
  logic               ge;
  logic [DW:0]        rem_nxt;
  logic [QW-1:0]      fat_raw;
  logic [DISK_W-1:0]  data;

  assign cb      = spc_r * bps_r;
  assign num     = disk_r * eb_r;
  assign den     = {22'd0, eb_r} + {1'b0, cb, 3'b000};
  assign r2      = {rem_r[DW-1:0], q_r[QW-1]};
  assign ge      = r2 >= {1'b0, den_r};
  assign rem_nxt = ge ? r2 - {1'b0, den_r} : r2;
  assign fat_raw = (den_r == '0) ? '0 : q_r + QW'(rem_r != '0);
  assign data    = (fat_r > {8'd0, disk_r}) ? '0 : disk_r - fat_r[DISK_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_r  <= 40'd1048576;
      spc_r   <= 8'd1;
      bps_r   <= 16'd512;
      eb_r    <= 6'd16;
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      limit_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISK_BYTES: disk_r <= cfg_wdata;
        CFG_SPC:        spc_r  <= cfg_wdata[SPC_W-1:0];
        CFG_BPS:        bps_r  <= cfg_wdata[BPS_W-1:0];
        CFG_ENTRY_BITS: eb_r   <= cfg_wdata[EB_W-1:0];
        default: ;
      endcase
      valid_r <= 1'b0;
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!valid_r) begin
            q_r     <= {2'b00, num};
            rem_r   <= '0;
            den_r   <= den;
            cnt_r   <= '0;
            state_r <= S_DIV1;
          end
        end
        S_DIV1, S_DIV2, S_DIV3: begin
          q_r   <= {q_r[QW-2:0], ge};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == DIV_LAST) begin
            unique case (state_r)
              S_DIV1:  state_r <= S_RAW;
              S_DIV2:  state_r <= S_ROUND;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_RAW: begin
          fat_r <= fat_raw;
          if (bps_r == '0) begin
            state_r <= S_DATA;
          end else begin
            q_r     <= fat_raw;
            rem_r   <= '0;
            den_r   <= {12'd0, bps_r};
            cnt_r   <= '0;
            state_r <= S_DIV2;
          end
        end
        S_ROUND: begin
          if (rem_r != '0) begin
            fat_r <= fat_r + {32'd0, bps_r - rem_r[BPS_W-1:0]};
          end
          state_r <= S_DATA;
        end
        S_DATA: begin
          if (cb == '0) begin
            limit_r <= '0;
            valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            q_r     <= {8'd0, data};
            rem_r   <= '0;
            den_r   <= {4'd0, cb};
            cnt_r   <= '0;
            state_r <= S_DIV3;
          end
        end
        S_DONE: begin
          limit_r <= q_r[LIMIT_W-1:0];
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign lim.valid = valid_r;
  assign lim.limit = limit_r;
  assign bps       = bps_r;
  assign eb        = eb_r;

endmodule

/* hdl/fel_front.sv */
module fel_front
  import fel_pkg::*;
(
  input  logic                    push,
  input  logic [CLUSTER_BITS-1:0] cluster_index,
  input  lim_t                    lim,
  input  logic [BPS_W-1:0]        bps,
  input  logic [EB_W-1:0]         eb,
  input  logic                    q_full,
  output logic                    full,
  output logic                    q_push,
  output item_t                   q_item
);

  assign full          = !lim.valid || q_full;
  assign q_push        = push && !full;
  assign q_item.oor    = ({9'd0, cluster_index} >= lim.limit) || (bps == '0);
  assign q_item.bitpos = cluster_index * eb;

endmodule

/* hdl/fel_queue.sv */
module fel_queue
  import fel_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t din,
  output logic  full,
  input  logic  pop,
  output item_t dout,
  output logic  empty
);

  item_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QPTR_W:0]   cnt_r;

  assign full  = cnt_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign dout  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

/* hdl/fel_back.sv */
module fel_back
  import fel_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  item_t               q_item,
  output logic                q_pop,
  input  logic [BPS_W-1:0]    bps,
  input  logic                out_pop,
  output logic                out_empty,
  output logic [SECTOR_W-1:0] sector_number,
  output logic [BPS_W-1:0]    byte_in_sector,
  output logic [2:0]          bit_in_byte,
  output logic                out_of_range
);

  logic             v_r   [DIV_STEPS+1];
  logic             oor_r [DIV_STEPS+1];
  logic [2:0]       low_r [DIV_STEPS+1];
  logic [BPS_W-1:0] rem_r [DIV_STEPS+1];
  logic [DVD_W-1:0] dvd_r [DIV_STEPS+1];

  logic [BPS_W-1:0] rem_nxt [DIV_STEPS];
  logic [DVD_W-1:0] dvd_nxt [DIV_STEPS];
  logic [BPS_W:0]   r2      [DIV_STEPS];
  logic             en;

  assign en    = !v_r[DIV_STEPS] || out_pop;
  assign q_pop = en && !q_empty;

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      r2[k] = {rem_r[k], dvd_r[k][DVD_W-1]};
      if (r2[k] >= {1'b0, bps}) begin
        rem_nxt[k] = BPS_W'(r2[k] - {1'b0, bps});
        dvd_nxt[k] = {dvd_r[k][DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = r2[k][BPS_W-1:0];
        dvd_nxt[k] = {dvd_r[k][DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= !q_empty;
      for (int k = 0; k < DIV_STEPS; k++) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oor_r[0] <= q_item.oor;
      low_r[0] <= q_item.bitpos[2:0];
      rem_r[0] <= '0;
      dvd_r[0] <= q_item.bitpos[BITPOS_W-1:3];
      for (int k = 0; k < DIV_STEPS; k++) begin
        oor_r[k+1] <= oor_r[k];
        low_r[k+1] <= low_r[k];
        rem_r[k+1] <= rem_nxt[k];
        dvd_r[k+1] <= dvd_nxt[k];
      end
    end
  end

  assign out_empty      = !v_r[DIV_STEPS];
  assign out_of_range   = oor_r[DIV_STEPS];
  assign sector_number  = oor_r[DIV_STEPS] ? '0 : dvd_r[DIV_STEPS][SECTOR_W-1:0];
  assign byte_in_sector = oor_r[DIV_STEPS] ? '0 : rem_r[DIV_STEPS];
  assign bit_in_byte    = oor_r[DIV_STEPS] ? '0 : low_r[DIV_STEPS];

endmodule

/* hdl/fat_entry_locator.sv */
// channel | ports                                   | direction
// request | in_push, in_full, in_cluster_index      | in
// result  | out_empty, out_pop, out_sector_number,  | out
//         | out_byte_in_sector, out_bit_in_byte,    |
//         | out_out_of_range                        |
// config  | cfg_we, cfg_index, cfg_wdata            | in
// One request per cycle while in_full is low; a request passes the queue, an input stage and 35 one-bit divider steps.
// After reset and after every config write in_full stays high while
// the serial 48-step divider recomputes the cluster limit (up to three divisions).
// A stalled result holds the divider pipeline; a 4-entry queue keeps accepting until full.
module fat_entry_locator
  import fel_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [CLUSTER_BITS-1:0] in_cluster_index,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [SECTOR_W-1:0]     out_sector_number,
  output logic [BPS_W-1:0]        out_byte_in_sector,
  output logic [2:0]              out_bit_in_byte,
  output logic                    out_out_of_range,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DISK_W-1:0]       cfg_wdata
);

  lim_t             lim;
  logic [BPS_W-1:0] bps;
  logic [EB_W-1:0]  eb;
  logic             q_full;
  logic             q_push;
  item_t            q_din;
  logic             q_pop;
  item_t            q_dout;
  logic             q_empty;

  fel_limit u_limit (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .lim       (lim),
    .bps       (bps),
    .eb        (eb)
  );

  fel_front u_front (
    .push          (in_push),
    .cluster_index (in_cluster_index),
    .lim           (lim),
    .bps           (bps),
    .eb            (eb),
    .q_full        (q_full),
    .full          (in_full),
    .q_push        (q_push),
    .q_item        (q_din)
  );

  fel_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  fel_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_item         (q_dout),
    .q_pop          (q_pop),
    .bps            (bps),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .sector_number  (out_sector_number),
    .byte_in_sector (out_byte_in_sector),
    .bit_in_byte    (out_bit_in_byte),
    .out_of_range   (out_out_of_range)
  );

  a_full_while_stale: assert property (@(posedge clk) disable iff (!rst_n)
    !lim.valid |-> in_full)
    else $error("request taken with stale cluster limit");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_full)
    else $error("config write did not block requests");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_out_of_range) |->
      (out_sector_number == '0 && out_byte_in_sector == '0 && out_bit_in_byte == '0))
    else $error("out of range result carries nonzero location");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("queue overflow");

endmodule
